// ===== rtl/mat_pkg.sv =====
package mat_pkg;

	// Default table depth, overridable at the top level
	parameter int DEPTH_DEF = 16;

	// Fixed field widths
	localparam int ADDR_W  = 48;
	localparam int COUNT_W = 5;

	// Request kinds
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_DEL = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic valid;     // entry lies below the count
		logic load_new;  // take the request address
		logic shift_in;  // take the neighbor's entry
	} cell_ctl_t;

endpackage

// ===== rtl/mat_req_if.sv =====
interface mat_req_if import mat_pkg::*;;
	logic              valid;
	logic              ready;
	logic              op;
	logic [ADDR_W-1:0] mac_address;

	modport source (output valid, output op, output mac_address, input ready);
	modport sink   (input valid, input op, input mac_address, output ready);
endinterface

// ===== rtl/mat_rsp_if.sv =====
interface mat_rsp_if import mat_pkg::*;;
	logic               valid;
	logic               ready;
	logic               rejected;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, output rejected, output entry_count, input ready);
	modport sink   (input valid, input rejected, input entry_count, output ready);
endinterface

// ===== rtl/mat_cell.sv =====
module mat_cell import mat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [ADDR_W-1:0] addr,
	input  logic [ADDR_W-1:0] next_entry,
	output logic [ADDR_W-1:0] entry,
	output logic              match_s1
);

	logic [ADDR_W-1:0] entry_q;

	// Hold the entry; load a new address or pull down from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			entry_q <= addr;
		end else if (ctl.shift_in) begin
			entry_q <= next_entry;
		end
	end

	// Compare against the pending request, only while the entry is in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
		end else begin
			match_s1 <= ctl.valid && (entry_q == addr);
		end
	end

	assign entry = entry_q;

endmodule

// ===== rtl/mat_ctrl.sv =====
module mat_ctrl import mat_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mat_req_if.sink               req,
	mat_rsp_if.source             rsp,
	input  logic [TABLE_DEPTH-1:0] match,
	output logic [ADDR_W-1:0]     addr,
	output cell_ctl_t             cell_ctl [TABLE_DEPTH]
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	state_t              state_q, state_d;
	logic                op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                out_valid_q;
	logic                rejected_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                done;
	logic                accept;
	logic                any_hit;
	logic                full;
	logic                rej;
	logic [IDX_W-1:0]    hit_idx;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	// Finish an update once the output register can take the result
	assign done   = (state_q == ST_UPD) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE) || done;
	assign accept = req.valid && req.ready;

	// Encode the single matching cell
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign any_hit = |match;
	assign full    = (count_q == CNT_W'(TABLE_DEPTH));
	assign rej     = (op_q == OP_ADD) ? (full || any_hit) : !any_hit;

	// Next count after the request
	always_comb begin
		count_d = count_q;
		if (!rej) begin
			if (op_q == OP_ADD) begin
				count_d = count_q + CNT_W'(1);
			end else begin
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	// Drive the cells: append at the count, or close the gap above the hit
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			cell_ctl[i].valid    = (CNT_W'(i) < count_q);
			cell_ctl[i].load_new = done && !rej && (op_q == OP_ADD)
				&& (CNT_W'(i) == count_q);
			cell_ctl[i].shift_in = done && !rej && (op_q == OP_DEL)
				&& (IDX_W'(i) >= hit_idx);
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (done) state_d = accept ? ST_CMP : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			addr_q <= req.mac_address;
		end
	end

	// Advance the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (done) begin
			count_q <= count_d;
		end
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_d};

	// Output register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rejected_q  <= rej;
			out_count_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.rejected    = rejected_q;
	assign rsp.entry_count = out_count_q;
	assign addr            = addr_q;

	// Valid entries are distinct, so at most one cell matches
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one cell matches");

	// Count never passes the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("count beyond table depth");

	// An accepted add grows the count by one
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rej && (op_q == OP_ADD) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("add did not grow count");

	// No new request while comparing
	a_busy_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> !req.ready)
		else $error("request taken during compare");

	// A finished result always lands in the output register
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("result lost");

endmodule

// ===== rtl/multicast_address_table.sv =====
// Channel | Dir | Payload                      | Transfer
// req     | in  | op, mac_address[47:0]        | valid && ready
// rsp     | out | rejected, entry_count[4:0]   | valid && ready
//
// Each request passes through a compare step, in which every cell compares its
// entry with the address, and an update step, in which the cells append or shift down.
// A new request is taken in the cycle the previous one finishes.
// The update step waits while the output register still holds a result.
// Reset clears the count; entry contents are undefined until written.
module multicast_address_table import mat_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mat_req_if.sink   req,
	mat_rsp_if.source rsp
);

	logic [TABLE_DEPTH-1:0] match;
	logic [ADDR_W-1:0]      addr;
	cell_ctl_t              cell_ctl [TABLE_DEPTH];
	logic [ADDR_W-1:0]      entry [TABLE_DEPTH];

	mat_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.match    (match),
		.addr     (addr),
		.cell_ctl (cell_ctl)
	);

	// Row of cells, each pulling from its upper neighbor on delete
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [ADDR_W-1:0] next_entry;

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_entry = entry[i];
		end else begin : g_mid
			assign next_entry = entry[i+1];
		end

		mat_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[i]),
			.addr       (addr),
			.next_entry (next_entry),
			.entry      (entry[i]),
			.match_s1   (match[i])
		);
	end

endmodule

// ===== test/tb.sv =====
module tb;
	import mat_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int N_DIRECTED     = 27;
	localparam int N_RANDOM       = 1323;
	localparam int POOL_SIZE      = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_WAIT       = 17;

	typedef struct packed {
		logic               rejected;
		logic [COUNT_W-1:0] entry_count;
	} table_result_t;

	typedef struct packed {
		logic               op;
		logic [ADDR_W-1:0]  addr;
		logic               typed;     // expectation given in the row
		logic               rejected;
		logic [COUNT_W-1:0] entry_count;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mat_req_if req_ch ();
	mat_rsp_if rsp_ch ();

	multicast_address_table #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the address list
	logic [ADDR_W-1:0] table_addr [DEPTH];
	int                table_count;

	table_result_t     pending_results [$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	stim_row_t         directed_rows [N_DIRECTED];

	int fail_count;
	int idle_cycles;
	bit send_burst;
	bit recv_burst;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow list and return its outcome
	function automatic table_result_t update_table(logic op, logic [ADDR_W-1:0] addr);
		int hit;
		table_result_t r;
		hit = -1;
		for (int k = 0; k < table_count; k++)
			if (hit < 0 && table_addr[k] == addr)
				hit = k;
		r.rejected = 1'b1;
		if (op == OP_ADD) begin
			if (table_count < DEPTH && hit < 0) begin
				table_addr[table_count] = addr;
				table_count++;
				r.rejected = 1'b0;
			end
		end else if (hit >= 0) begin
			for (int k = hit + 1; k < table_count; k++)
				table_addr[k-1] = table_addr[k];
			table_count--;
			r.rejected = 1'b0;
		end
		r.entry_count = table_count[COUNT_W-1:0];
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_W-1:0];
	endfunction

	// Present one request, hold it until the transfer, record the expected outcome
	task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
			input logic typed, input logic exp_rej, input logic [COUNT_W-1:0] exp_cnt);
		int gap;
		table_result_t pred;
		gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.mac_address <= addr;
		do @(posedge clk); while (!req_ch.ready);
		pred = update_table(op, addr);
		if (typed) begin
			pred.rejected    = exp_rej;
			pred.entry_count = exp_cnt;
		end
		pending_results.push_back(pred);
	endtask

	// Draw a request: filling phases favor adds, draining phases favor deletes
	task automatic pick_request(input bit fill_phase, output logic op,
			output logic [ADDR_W-1:0] addr);
		int roll;
		int bit_idx;
		roll = $urandom_range(0, 99);
		op = (fill_phase ? (roll >= 85) : (roll < 85)) ? OP_DEL : OP_ADD;
		roll = $urandom_range(0, 99);
		if (op == OP_DEL && table_count > 0 && roll < 70) begin
			addr = table_addr[$urandom_range(0, table_count - 1)];
		end else if (op == OP_ADD && table_count > 0 && roll < 10) begin
			// near miss: one bit away from a stored address
			addr = table_addr[$urandom_range(0, table_count - 1)];
			bit_idx = $urandom_range(0, ADDR_W - 1);
			addr[bit_idx] = ~addr[bit_idx];
		end else if (roll < 80) begin
			addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else begin
			addr = random_address();
		end
	endtask

	// Count cycles without any transfer and stop a hung run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Accept results with random stalls and compare with the oldest expectation
	initial begin
		int stall;
		int n_results;
		table_result_t exp_res;
		n_results = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (n_results % 40 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result rejected=%0b entry_count=%0d", $time,
					rsp_ch.rejected, rsp_ch.entry_count);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (rsp_ch.rejected !== exp_res.rejected) begin
					$display("%0t: rejected expected %0b actual %0b", $time,
						exp_res.rejected, rsp_ch.rejected);
					fail_count++;
				end
				if (rsp_ch.entry_count !== exp_res.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d", $time,
						exp_res.entry_count, rsp_ch.entry_count);
					fail_count++;
				end
			end
		end
	end

	// Reset, directed table, random requests, drain and verdict
	initial begin
		int phase_left;
		bit fill_phase;
		logic op;
		logic [ADDR_W-1:0] addr;
		stim_row_t row;

		fail_count  = 0;
		table_count = 0;
		send_burst  = 1'b0;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.op          <= OP_ADD;
		req_ch.mac_address <= '0;

		for (int k = 0; k < POOL_SIZE; k++)
			addr_pool[k] = random_address();

		// empty table, extremes, duplicate and miss
		directed_rows[0] = '{OP_DEL, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 5'd0};
		directed_rows[1] = '{OP_ADD, 48'h0000_0000_0000, 1'b1, 1'b0, 5'd1};
		directed_rows[2] = '{OP_ADD, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 5'd2};
		directed_rows[3] = '{OP_ADD, 48'h0000_0000_0000, 1'b1, 1'b1, 5'd2};
		directed_rows[4] = '{OP_DEL, 48'h0000_0000_0001, 1'b1, 1'b1, 5'd2};
		directed_rows[5] = '{OP_DEL, 48'h0000_0000_0000, 1'b1, 1'b0, 5'd1};
		directed_rows[6] = '{OP_DEL, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 5'd0};
		directed_rows[7] = '{OP_ADD, 48'h8000_0000_0000, 1'b1, 1'b0, 5'd1};
		directed_rows[8] = '{OP_ADD, 48'h7FFF_FFFF_FFFF, 1'b1, 1'b0, 5'd2};
		// fill the table
		for (int k = 9; k < 23; k++)
			directed_rows[k] = '{OP_ADD, 48'h0100_5E00_0000 + k, 1'b0, 1'b0, 5'd0};
		// full table: new address, then an address already present
		directed_rows[23] = '{OP_ADD, 48'h0100_5EFF_FFFF, 1'b1, 1'b1, COUNT_W'(DEPTH)};
		directed_rows[24] = '{OP_ADD, 48'h8000_0000_0000, 1'b1, 1'b1, COUNT_W'(DEPTH)};
		// delete from the middle and from the front
		directed_rows[25] = '{OP_DEL, 48'h0100_5E00_000F, 1'b0, 1'b0, 5'd0};
		directed_rows[26] = '{OP_DEL, 48'h8000_0000_0000, 1'b0, 1'b0, 5'd0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_rows[i];
			send_request(row.op, row.addr, row.typed, row.rejected, row.entry_count);
		end

		phase_left = 0;
		fill_phase = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			// alternate filling and draining so the table swings between empty and full
			if (phase_left == 0) begin
				fill_phase = ~fill_phase;
				phase_left = $urandom_range(20, 80);
			end
			phase_left--;
			if (i % 50 == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			if (i % 150 == 0)
				addr_pool[$urandom_range(0, POOL_SIZE - 1)] = random_address();
			pick_request(fill_phase, op, addr);
			send_request(op, addr, 1'b0, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		// drain outstanding results, then wait before the verdict
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
